// ===== rtl/lpmd_pkg.sv =====
package lpmd_pkg;

	// Header is a 32-bit type word then a 32-bit signed length, little endian
	localparam int unsigned HdrLen = 8;
	localparam int unsigned HdrCntW = 3;
	localparam logic [15:0] MaxPayloadReset = 16'd992;

	typedef enum logic {
		ST_HEADER,
		ST_PAYLOAD
	} lpmd_state_t;

	// Control from the input stage to the framing core
	typedef struct packed {
		logic       present;
		logic       commit;
		logic [7:0] data_byte;
	} lpmd_step_t;

	typedef struct packed {
		logic [31:0] msg_type;
		logic [7:0]  payload_byte;
		logic        has_byte;
		logic        first_of_msg;
		logic        last_of_msg;
		logic        length_error;
	} lpmd_result_t;

endpackage

// ===== rtl/lpmd_byte_if.sv =====
interface lpmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/lpmd_msg_if.sv =====
interface lpmd_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_type;
	logic [7:0]  payload_byte;
	logic        has_byte;
	logic        first_of_msg;
	logic        last_of_msg;
	logic        length_error;

	modport source (output valid, output msg_type, output payload_byte, output has_byte,
		output first_of_msg, output last_of_msg, output length_error, input ready);
	modport sink (input valid, input msg_type, input payload_byte, input has_byte,
		input first_of_msg, input last_of_msg, input length_error, output ready);
endinterface

// ===== rtl/lpmd_core.sv =====
module lpmd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpmd_pkg::lpmd_step_t  step,
	input  logic [15:0]           max_payload,
	output lpmd_pkg::lpmd_result_t result,
	output logic                  result_valid
);
	import lpmd_pkg::*;

	lpmd_state_t        state_q, state_d;
	logic [6:0][7:0]    hdr_q;
	logic [HdrCntW-1:0] hdr_cnt_q;
	logic [31:0]        type_q;
	logic [15:0]        left_q;
	logic               first_q;

	logic        hdr_done;
	logic [31:0] len;
	logic        len_bad;
	logic        len_zero;
	logic        pay_last;

	// Decode the header length as it completes
	assign hdr_done = (hdr_cnt_q == HdrCntW'(HdrLen - 1));
	assign len      = {step.data_byte, hdr_q[6], hdr_q[5], hdr_q[4]};
	assign len_bad  = len[31] || (len[30:16] != 15'd0) || (len[15:0] > max_payload);
	assign len_zero = (len == 32'd0);
	assign pay_last = (left_q <= 16'd1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HEADER: begin
				if (hdr_done && !len_bad && !len_zero)
					state_d = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				if (pay_last)
					state_d = ST_HEADER;
			end
			default: state_d = ST_HEADER;
		endcase
	end

	// Result for the byte at hand
	always_comb begin
		result       = '0;
		result_valid = 1'b0;
		case (state_q)
			ST_HEADER: begin
				result_valid        = step.present && hdr_done && (len_bad || len_zero);
				result.msg_type     = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
				result.first_of_msg = 1'b1;
				result.last_of_msg  = 1'b1;
				result.length_error = len_bad;
			end
			ST_PAYLOAD: begin
				result_valid        = step.present;
				result.msg_type     = type_q;
				result.payload_byte = step.data_byte;
				result.has_byte     = 1'b1;
				result.first_of_msg = first_q;
				result.last_of_msg  = pay_last;
			end
			default: begin
				result_valid = 1'b0;
			end
		endcase
	end

	// Advance framing state on each committed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HEADER;
			hdr_cnt_q <= '0;
			type_q    <= '0;
			left_q    <= '0;
			first_q   <= 1'b0;
			hdr_q     <= '0;
		end else if (step.commit) begin
			state_q <= state_d;
			if (state_q == ST_HEADER) begin
				if (hdr_done) begin
					hdr_cnt_q <= '0;
					type_q    <= {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
					left_q    <= len[15:0];
					first_q   <= !len_bad && !len_zero;
				end else begin
					hdr_q[hdr_cnt_q] <= step.data_byte;
					hdr_cnt_q        <= hdr_cnt_q + 1'b1;
				end
			end else begin
				left_q  <= left_q - 16'd1;
				first_q <= 1'b0;
			end
		end
	end

	// A payload phase always has bytes left to count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAYLOAD |-> left_q != 16'd0)
		else $error("payload phase with zero bytes left");

	// First-byte mark lives only inside a payload
	assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> state_q == ST_PAYLOAD)
		else $error("first mark set outside payload");

	// A header-phase result never carries a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && state_q == ST_HEADER |-> !result.has_byte && hdr_done)
		else $error("header result with byte or before header end");

endmodule

// ===== rtl/length_prefixed_message_deframer.sv =====
// Path: a byte accepted into the input stage register is framed by the combinational core and,
//   if it makes a result, is registered in the result register before it shows at the output.
// Throughput: one byte per cycle; the input stage and the output register stall only
//   when the output side holds a result that has not been taken.
// Reset: arst_n clears framing to header collection and the maximum payload length (max_q) to 992.
module length_prefixed_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	lpmd_byte_if.sink   byte_stream,
	lpmd_msg_if.source  msg_stream,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import lpmd_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	lpmd_result_t out_q;
	logic [15:0]  max_q;

	lpmd_step_t   step;
	lpmd_result_t core_res;
	logic         core_valid;
	logic         out_free;
	logic         s1_adv;

	// Move a byte on when it makes no result or the output slot is free
	assign out_free          = !out_valid_q || msg_stream.ready;
	assign s1_adv            = valid_s1 && (!core_valid || out_free);
	assign byte_stream.ready = !valid_s1 || s1_adv;

	assign step.present   = valid_s1;
	assign step.commit    = s1_adv;
	assign step.data_byte = byte_s1;

	lpmd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.max_payload  (max_q),
		.result       (core_res),
		.result_valid (core_valid)
	);

	// Hold the maximum length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= MaxPayloadReset;
		else if (cfg_wr_en)
			max_q <= cfg_wr_data;
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_stream.ready)
			valid_s1 <= byte_stream.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid)
			byte_s1 <= byte_stream.data_byte;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1 && core_valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && core_valid)
			out_q <= core_res;
	end

	assign msg_stream.valid        = out_valid_q;
	assign msg_stream.msg_type     = out_q.msg_type;
	assign msg_stream.payload_byte = out_q.payload_byte;
	assign msg_stream.has_byte     = out_q.has_byte;
	assign msg_stream.first_of_msg = out_q.first_of_msg;
	assign msg_stream.last_of_msg  = out_q.last_of_msg;
	assign msg_stream.length_error = out_q.length_error;

	// A stalled input byte stays in the stage
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && byte_s1 == $past(byte_s1))
		else $error("input stage lost a stalled byte");

	// An error request is a bare one-result message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.length_error |-> !out_q.has_byte && out_q.first_of_msg
			&& out_q.last_of_msg)
		else $error("error request malformed");

	// A request without a byte opens and closes its message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_byte |-> out_q.first_of_msg && out_q.last_of_msg)
		else $error("empty request not marked first and last");

endmodule

// ===== tb/tb_length_prefixed_message_deframer.sv =====
module tb_length_prefixed_message_deframer;
	import lpmd_pkg::*;

	localparam int unsigned CycleLimit = 4_000_000;
	localparam int unsigned DrainCycles = 4;
	localparam int unsigned PhaseItems = 200;

	// Track framing state and queue the expected message requests
	class deframer_scoreboard;
		logic [15:0]  max_len;
		logic [63:0]  hdr_acc;
		logic [3:0]   hdr_cnt;
		logic [31:0]  cur_word;
		logic [15:0]  left;
		lpmd_state_t  phase;
		logic         first_pending;
		lpmd_result_t expected_q[$];
		int unsigned  errors;

		function new();
			max_len = MaxPayloadReset;
			hdr_acc = '0;
			hdr_cnt = '0;
			cur_word = '0;
			left = '0;
			phase = ST_HEADER;
			first_pending = 1'b0;
			errors = 0;
		endfunction

		function void set_max(logic [15:0] v);
			max_len = v;
		endfunction

		function bit idle();
			return expected_q.size() == 0;
		endfunction

		// Advance the framing state by one accepted byte request
		function void note_byte(logic [7:0] b);
			lpmd_result_t r;
			logic [31:0] len;
			r = '0;
			if (phase == ST_PAYLOAD) begin
				if (left != 0)
					left = left - 1;
				r.msg_type = cur_word;
				r.payload_byte = b;
				r.has_byte = 1'b1;
				r.first_of_msg = first_pending;
				r.last_of_msg = (left == 0);
				first_pending = 1'b0;
				if (left == 0)
					phase = ST_HEADER;
				expected_q.push_back(r);
				return;
			end
			hdr_acc[hdr_cnt[2:0] * 8 +: 8] = b;
			hdr_cnt = {1'b0, hdr_cnt[2:0]} + 4'd1;
			if (hdr_cnt < HdrLen)
				return;
			cur_word = hdr_acc[31:0];
			len = hdr_acc[63:32];
			hdr_acc = '0;
			hdr_cnt = '0;
			r.msg_type = cur_word;
			r.first_of_msg = 1'b1;
			r.last_of_msg = 1'b1;
			if (len[31] || len > {16'd0, max_len}) begin
				r.length_error = 1'b1;
				expected_q.push_back(r);
			end else if (len == 0) begin
				expected_q.push_back(r);
			end else begin
				left = len[15:0];
				phase = ST_PAYLOAD;
				first_pending = 1'b1;
			end
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction

		// Compare a delivered request against the oldest expectation
		function void check_result(lpmd_result_t got);
			lpmd_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected message request: msg_type %0h payload_byte %0h",
					got.msg_type, got.payload_byte);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("msg_type", exp_r.msg_type, got.msg_type);
			compare_field("payload_byte", exp_r.payload_byte, got.payload_byte);
			compare_field("has_byte", exp_r.has_byte, got.has_byte);
			compare_field("first_of_msg", exp_r.first_of_msg, got.first_of_msg);
			compare_field("last_of_msg", exp_r.last_of_msg, got.last_of_msg);
			compare_field("length_error", exp_r.length_error, got.length_error);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	lpmd_byte_if byte_bus ();
	lpmd_msg_if  msg_bus ();

	deframer_scoreboard sb;

	int unsigned  cycle_count;
	int unsigned  bytes_sent;
	int unsigned  burst_left;
	int unsigned  stall_left;
	int unsigned  stall_mode;
	lpmd_result_t got_msg;

	length_prefixed_message_deframer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_bus),
		.msg_stream (msg_bus),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sink side: check delivered requests, stall on a changing pattern
	always @(posedge clk) begin
		if (arst_n && msg_bus.valid && msg_bus.ready) begin
			got_msg.msg_type = msg_bus.msg_type;
			got_msg.payload_byte = msg_bus.payload_byte;
			got_msg.has_byte = msg_bus.has_byte;
			got_msg.first_of_msg = msg_bus.first_of_msg;
			got_msg.last_of_msg = msg_bus.last_of_msg;
			got_msg.length_error = msg_bus.length_error;
			sb.check_result(got_msg);
		end
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(2, 0);
			stall_left <= $urandom_range(400, 50);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: begin
				msg_bus.ready <= 1'b1;
			end
			1: begin
				msg_bus.ready <= $urandom_range(1, 0);
			end
			default: begin
				msg_bus.ready <= (cycle_count % 3) != 0;
			end
		endcase
	end

	// Send one byte request; open a new burst after a random gap when the last one ran out
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(32, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				byte_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		do @(posedge clk); while (!byte_bus.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] word, input logic [31:0] len);
		logic [63:0] hdr;
		hdr = {len, word};
		for (int i = 0; i < 8; i++)
			send_byte(hdr[i * 8 +: 8]);
	endtask

	// Send a header and, when the length is accepted, that many random payload bytes
	task automatic send_message(input logic [31:0] word, input logic [31:0] len);
		int unsigned n;
		send_header(word, len);
		n = (!len[31] && len <= {16'd0, sb.max_len}) ? len : 0;
		for (int unsigned i = 0; i < n; i++)
			send_byte($urandom_range(255, 0));
	endtask

	// Mostly short lengths of up to 24 bytes, with empty, boundary, negative and random lengths mixed in
	task automatic random_message();
		int unsigned pick;
		logic [31:0] len;
		pick = $urandom_range(99, 0);
		if (pick < 8)
			len = 0;
		else if (pick < 13)
			len = (sb.max_len <= 300) ? {16'd0, sb.max_len} : $urandom_range(300, 1);
		else if (pick < 18)
			len = {16'd0, sb.max_len} + 32'd1;
		else if (pick < 23)
			len = {1'b1, 31'($urandom())};
		else if (pick < 30)
			len = $urandom();
		else
			len = $urandom_range(24, 1);
		send_message($urandom(), len);
	endtask

	// Hold off the sender until every expected request has come out
	task automatic drain_results();
		byte_bus.valid <= 1'b0;
		while (!sb.idle())
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_max(v);
	endtask

	initial begin
		logic [15:0] phase_max [5];
		int unsigned target;

		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		msg_bus.ready = 1'b0;
		cycle_count = 0;
		bytes_sent = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, negative length, one-byte payload
		send_message(32'hFFFF_FFFF, 32'd0);
		send_message(32'h0000_0000, 32'hFFFF_FFFF);
		send_header(32'h1234_5678, 32'd1);
		send_byte(8'hFF);

		// Lower the maximum in the middle of a payload; the current message stays valid
		send_header(32'hA5A5_0F0F, 32'd6);
		repeat (3) send_byte($urandom_range(255, 0));
		write_max_len(16'd0);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_message(32'h0000_0001, 32'd1);

		// Random phases over several maximums, extremes included
		phase_max[0] = 16'd0;
		phase_max[1] = 16'd65535;
		phase_max[2] = 16'd7;
		phase_max[3] = $urandom_range(300, 16);
		phase_max[4] = MaxPayloadReset;
		for (int p = 0; p < 5; p++) begin
			write_max_len(phase_max[p]);
			if (phase_max[p] == 16'd65535) begin
				send_message($urandom(), 32'd300);
				send_message($urandom(), 32'h0001_0000);
				send_message($urandom(), 32'h7FFF_FFFF);
				send_message($urandom(), 32'h8000_0000);
			end
			target = bytes_sent + PhaseItems;
			while (bytes_sent < target)
				random_message();
		end

		// Let everything settle and watch for stray requests
		drain_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== length_prefixed_message_deframer.f =====
rtl/lpmd_pkg.sv
rtl/lpmd_byte_if.sv
rtl/lpmd_msg_if.sv
rtl/lpmd_core.sv
rtl/length_prefixed_message_deframer.sv
tb/tb_length_prefixed_message_deframer.sv
